/* src/ibl_pkg.sv */
package ibl_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STAGES = DATA_W;
    // Sideband carried through the second divider: error flag and table block.
    localparam int DIV_SIDE_W = DATA_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INODES_PER_GROUP   = 3'd0,
        REG_GROUP_COUNT        = 3'd1,
        REG_BLOCKS_PER_GROUP   = 3'd2,
        REG_TABLE_BLOCK_OFFSET = 3'd3,
        REG_OLD_FORMAT         = 3'd4,
        REG_STAGGER_DELTA      = 3'd5,
        REG_STAGGER_MASK       = 3'd6,
        REG_INODES_PER_BLOCK   = 3'd7
    } cfg_index_t;

endpackage

/* src/ibl_div.sv */
module ibl_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [ibl_pkg::DATA_W-1:0]     dividend,
    input  logic [ibl_pkg::DATA_W-1:0]     divisor,
    input  logic [ibl_pkg::DIV_SIDE_W-1:0] side_in,
    output logic                           out_valid,
    output logic [ibl_pkg::DATA_W-1:0]     quotient,
    output logic [ibl_pkg::DATA_W-1:0]     remainder,
    output logic [ibl_pkg::DIV_SIDE_W-1:0] side_out
);
    import ibl_pkg::*;

    // One restoring step per stage; the quotient shifts in as the dividend
    // shifts out. A zero divisor yields all ones and the dividend as remainder.
    logic [DIV_STAGES-1:0] valid_reg;
    logic [DATA_W-1:0]     rem_reg  [DIV_STAGES];
    logic [DATA_W-1:0]     quo_reg  [DIV_STAGES];
    logic [DIV_SIDE_W-1:0] side_reg [DIV_STAGES];

    logic [DATA_W-1:0]     rem_prev [DIV_STAGES];
    logic [DATA_W-1:0]     quo_prev [DIV_STAGES];
    logic [DIV_SIDE_W-1:0] side_prev[DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_prev;
    logic [DATA_W:0]       trial    [DIV_STAGES];
    logic [DATA_W:0]       diff     [DIV_STAGES];
    logic [DATA_W-1:0]     rem_next [DIV_STAGES];
    logic [DATA_W-1:0]     quo_next [DIV_STAGES];

    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_prev[k]   = '0;
                quo_prev[k]   = dividend;
                side_prev[k]  = side_in;
                valid_prev[k] = in_valid;
            end
            else
            begin
                rem_prev[k]   = rem_reg[k-1];
                quo_prev[k]   = quo_reg[k-1];
                side_prev[k]  = side_reg[k-1];
                valid_prev[k] = valid_reg[k-1];
            end
            trial[k] = {rem_prev[k], quo_prev[k][DATA_W-1]};
            diff[k]  = trial[k] - {1'b0, divisor};
            if (trial[k] >= {1'b0, divisor})
            begin
                rem_next[k] = diff[k][DATA_W-1:0];
                quo_next[k] = {quo_prev[k][DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][DATA_W-1:0];
                quo_next[k] = {quo_prev[k][DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            quo_reg[k]  <= quo_next[k];
            side_reg[k] <= side_prev[k];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quotient  = quo_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

/* src/inode_block_locator_unit.sv */
// Inode block locator: for each inode number it returns the disk block that
// holds the inode and the slot inside that block, or flags a group beyond the
// group count (block and slot then read as zero). A beat is taken at any clock
// edge with start high; busy never rises, so one inode number may be issued in
// every cycle. Each result appears on the outputs for one cycle with done high,
// in issue order. The receiver cannot stall it, so it must take every beat as
// it comes. The path runs through two 32-stage one-bit-per-stage dividers
// (group split, then block split), a multiply stage and a table-add stage,
// plus the output register. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and must only change while no lookups are in
// flight.
module inode_block_locator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ibl_pkg::DATA_W-1:0]    inode_number,
    output logic                          done,
    output logic [ibl_pkg::DATA_W-1:0]    block_number,
    output logic [ibl_pkg::DATA_W-1:0]    slot_in_block,
    output logic                          group_out_of_range,
    input  logic                          cfg_we,
    input  logic [ibl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ibl_pkg::DATA_W-1:0]    cfg_data
);
    import ibl_pkg::*;

    // Configuration registers.
    logic [DATA_W-1:0] inodes_per_group_reg;
    logic [DATA_W-1:0] group_count_reg;
    logic [DATA_W-1:0] blocks_per_group_reg;
    logic [DATA_W-1:0] table_block_offset_reg;
    logic              old_format_reg;
    logic [DATA_W-1:0] stagger_delta_reg;
    logic [DATA_W-1:0] stagger_mask_reg;
    logic [DATA_W-1:0] inodes_per_block_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inodes_per_group_reg   <= DATA_W'(1);
            group_count_reg        <= '0;
            blocks_per_group_reg   <= '0;
            table_block_offset_reg <= '0;
            old_format_reg         <= 1'b0;
            stagger_delta_reg      <= '0;
            stagger_mask_reg       <= '0;
            inodes_per_block_reg   <= DATA_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_INODES_PER_GROUP:   inodes_per_group_reg   <= cfg_data;
                REG_GROUP_COUNT:        group_count_reg        <= cfg_data;
                REG_BLOCKS_PER_GROUP:   blocks_per_group_reg   <= cfg_data;
                REG_TABLE_BLOCK_OFFSET: table_block_offset_reg <= cfg_data;
                REG_OLD_FORMAT:         old_format_reg         <= cfg_data[0];
                REG_STAGGER_DELTA:      stagger_delta_reg      <= cfg_data;
                REG_STAGGER_MASK:       stagger_mask_reg       <= cfg_data;
                REG_INODES_PER_BLOCK:   inodes_per_block_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline never backs up, so every start beat is taken.
    assign busy = 1'b0;

    // First divider: inode number over inodes per group gives the group and
    // the offset inside it.
    logic              grp_valid;
    logic [DATA_W-1:0] grp_quo;
    logic [DATA_W-1:0] grp_rem;
    logic [DIV_SIDE_W-1:0] grp_side_unused;

    ibl_div u_group_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .dividend  (inode_number),
        .divisor   (inodes_per_group_reg),
        .side_in   ('0),
        .out_valid (grp_valid),
        .quotient  (grp_quo),
        .remainder (grp_rem),
        .side_out  (grp_side_unused)
    );

    // Multiply stage: group times blocks per group, and the UFS1 stagger term
    // (group with the cycle mask bits cleared, times the stagger step).
    logic              mul_valid_reg;
    logic              mul_err_reg;
    logic [DATA_W-1:0] mul_base_reg;
    logic [DATA_W-1:0] mul_stag_reg;
    logic [DATA_W-1:0] mul_offs_reg;
    logic [DATA_W-1:0] mul_stag_grp;

    assign mul_stag_grp = old_format_reg ? (grp_quo & ~stagger_mask_reg) : '0;

    // Table stage: sum the base, stagger and table offset.
    logic              tbl_valid_reg;
    logic              tbl_err_reg;
    logic [DATA_W-1:0] tbl_block_reg;
    logic [DATA_W-1:0] tbl_offs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            tbl_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= grp_valid;
            tbl_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_err_reg   <= (grp_quo >= group_count_reg);
        mul_base_reg  <= DATA_W'(grp_quo * blocks_per_group_reg);
        mul_stag_reg  <= DATA_W'(mul_stag_grp * stagger_delta_reg);
        mul_offs_reg  <= grp_rem;
        tbl_err_reg   <= mul_err_reg;
        tbl_block_reg <= mul_base_reg + mul_stag_reg + table_block_offset_reg;
        tbl_offs_reg  <= mul_offs_reg;
    end

    // Second divider: the in-group offset over inodes per block; the table
    // block and error flag ride along as sideband.
    logic                  blk_valid;
    logic [DATA_W-1:0]     blk_quo;
    logic [DATA_W-1:0]     blk_rem;
    logic [DIV_SIDE_W-1:0] blk_side;

    ibl_div u_block_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tbl_valid_reg),
        .dividend  (tbl_offs_reg),
        .divisor   (inodes_per_block_reg),
        .side_in   ({tbl_err_reg, tbl_block_reg}),
        .out_valid (blk_valid),
        .quotient  (blk_quo),
        .remainder (blk_rem),
        .side_out  (blk_side)
    );

    // Output register: one beat per cycle that done is high.
    logic              done_reg;
    logic [DATA_W-1:0] block_reg;
    logic [DATA_W-1:0] slot_reg;
    logic              err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= blk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= blk_side[DATA_W];
        block_reg <= blk_side[DATA_W] ? '0 : (blk_side[DATA_W-1:0] + blk_quo);
        slot_reg  <= blk_side[DATA_W] ? '0 : blk_rem;
    end

    assign done               = done_reg;
    assign block_number       = block_reg;
    assign slot_in_block      = slot_reg;
    assign group_out_of_range = err_reg;

    // An out-of-range group always reports zero block and slot.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && group_out_of_range |-> block_number == '0 && slot_in_block == '0)
        else $error("out-of-range result carries a nonzero block or slot");

    // The block never refuses a beat.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every beat leaving the second divider reaches the output as a result beat.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid |=> done)
        else $error("divider beat did not reach the output");

endmodule
